// ===== rtl/core/elias_fano_block_encoder_macros.svh =====
// Assertion macros for the checker file.
`ifndef ELIAS_FANO_BLOCK_ENCODER_MACROS_SVH
`define ELIAS_FANO_BLOCK_ENCODER_MACROS_SVH

// Same-cycle implication, clocked on aclk, off during reset.
`define EFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk, off during reset.
`define EFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/efe_pkg.sv =====
package efe_pkg;

    localparam int DATA_BITS    = 64;
    localparam int WIDTH_BITS   = 7;
    localparam int HINT_BITS    = 10;
    localparam int OP_BITS      = 2;
    localparam int BLOCK_SIZE_D = 512;
    localparam int SUB_BLOCKS_D = 7;

    typedef enum logic [OP_BITS-1:0] {
        OP_APPEND = 2'd0,
        OP_CLOSE  = 2'd1,
        OP_FETCH  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WIDTH = 3'd1,
        PH_HINTS = 3'd2,
        PH_LOW   = 3'd3,
        PH_HIGH  = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_HINT_RD,
        ST_HINT_CALC,
        ST_FETCH,
        ST_FETCH_MEM,
        ST_PUSH
    } state_t;

    // Status of the low-width unit
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [WIDTH_BITS-1:0] width;
    } wdiv_stat_t;

endpackage

// ===== rtl/core/efe_ram.sv =====
module efe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/efe_wdiv.sv =====
// Two-stage width unit: find the bit length of the block total, then line its top
// bits up with the block size. The width result is the bit length of total / BLOCK_SIZE.
module efe_wdiv #(
    parameter int BLOCK_SIZE = efe_pkg::BLOCK_SIZE_D
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [efe_pkg::DATA_BITS-1:0] dividend,
    output efe_pkg::wdiv_stat_t          stat
);
    import efe_pkg::*;

    localparam int BW = $clog2(BLOCK_SIZE + 1);
    localparam int LW = $clog2(DATA_BITS + 1);
    localparam logic [BW-1:0] DIVISOR = BW'(BLOCK_SIZE);

    logic [DATA_BITS-1:0]  tot_reg, tot_next;
    logic [LW-1:0]         len_reg, len_next;
    logic                  s1_reg, s2_reg, done_reg;
    logic [WIDTH_BITS-1:0] w_reg, w_next;
    logic [LW-1:0]         sh;
    logic [DATA_BITS-1:0]  top;
    logic                  ge;

    // Capture the total on start
    assign tot_next = start ? dividend : tot_reg;

    // Stage one: bit length of the total
    always_comb begin
        len_next = '0;
        for (int i = 0; i < DATA_BITS; i++) begin
            if (tot_reg[i]) begin
                len_next = LW'(i + 1);
            end
        end
    end

    // Stage two: align the top bits with the block size and compare
    assign sh  = len_reg - LW'(BW);
    assign top = tot_reg >> sh;
    assign ge  = (top[BW-1:0] >= DIVISOR);

    always_comb begin
        if (len_reg < LW'(BW)) begin
            w_next = '0;
        end else begin
            w_next = WIDTH_BITS'(sh) + WIDTH_BITS'(ge);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            done_reg <= 1'b0;
            w_reg    <= '0;
        end else begin
            s1_reg   <= start;
            s2_reg   <= s1_reg;
            done_reg <= s2_reg;
            w_reg    <= w_next;
        end
    end

    always_ff @(posedge aclk) begin
        tot_reg <= tot_next;
        len_reg <= len_next;
    end

    assign stat.busy  = s1_reg | s2_reg;
    assign stat.done  = done_reg;
    assign stat.width = w_reg;

endmodule

// ===== rtl/core/elias_fano_block_encoder.sv =====
// Append and a refused operation are handled in the idle state; close runs
// the prefix-sum walk over the memory port, the two-stage width unit and the
// hint reads. A fetch packs each width/hint chunk directly and takes one memory
// read for each low or unary chunk, then loads the output.
// Reset (aresetn low, synchronous) empties the block and idles the stream;
// the sum memory holds no reset.
module elias_fano_block_encoder #(
    parameter int BLOCK_SIZE = efe_pkg::BLOCK_SIZE_D,
    parameter int SUB_BLOCKS = efe_pkg::SUB_BLOCKS_D
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [efe_pkg::DATA_BITS-1:0] s_tdata,   // value
    input  logic [efe_pkg::OP_BITS-1:0]   s_tuser,   // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,   // out_word, bit_count, zero pad
    output logic                          m_tlast    // last_word
);
    import efe_pkg::*;

    localparam int IW   = $clog2(BLOCK_SIZE);
    localparam int CW   = $clog2(BLOCK_SIZE + 1);
    localparam int UW   = $clog2(2 * BLOCK_SIZE + 1);
    localparam int STEP = (BLOCK_SIZE + SUB_BLOCKS - 1) / SUB_BLOCKS;
    localparam int HW   = $clog2(BLOCK_SIZE + SUB_BLOCKS + STEP);
    localparam int PW   = $clog2(SUB_BLOCKS);
    localparam int FW   = WIDTH_BITS;
    localparam logic [IW-1:0] LAST_IDX = IW'(BLOCK_SIZE - 1);
    localparam logic [FW-1:0] FULL     = FW'(DATA_BITS);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    op_t    op;

    logic [CW-1:0]        count_reg, count_next;
    logic [IW-1:0]        scan_reg, scan_next;
    logic [DATA_BITS-1:0] acc_reg, acc_next;
    logic [FW-1:0]        lw_reg, lw_next;
    logic [DATA_BITS-1:0] hint_reg, hint_next;
    logic [PW-1:0]        hp_reg, hp_next;
    logic [HW-1:0]        hidx_reg, hidx_next;
    logic [IW-1:0]        eidx_reg, eidx_next;
    logic [UW-1:0]        upos_reg, upos_next;
    logic [DATA_BITS-1:0] pbuf_reg, pbuf_next;
    logic [FW-1:0]        pfill_reg, pfill_next;
    logic [DATA_BITS-1:0] word_reg, word_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic                 last_reg, last_next;
    logic                 mv_reg, mv_next;
    logic [71:0]          md_reg, md_next;
    logic                 ml_reg, ml_next;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    logic [DATA_BITS-1:0] ram_wdata, ram_rdata;
    logic                 div_start;
    logic [DATA_BITS-1:0] scan_sum;
    wdiv_stat_t           div_stat;

    logic [IW-1:0]        hidx_clamp;
    logic [UW-1:0]        hpos, gap;
    logic [DATA_BITS-1:0] ck_v;
    logic [FW-1:0]        ck_n;
    phase_t               ck_phase;
    logic [IW-1:0]        ck_idx;
    logic [UW-1:0]        ck_upos;
    logic [FW-1:0]        room;
    logic                 accept;

    // Unary position of a sum: saturated high part plus its index
    function automatic logic [UW-1:0] hi_pos(input logic [DATA_BITS-1:0] s,
                                             input logic [FW-1:0] w,
                                             input logic [IW-1:0] idx);
        logic [DATA_BITS-1:0] sh;
        logic [UW-1:0]        hi;
        sh = s >> w;
        hi = (sh > DATA_BITS'(BLOCK_SIZE)) ? UW'(BLOCK_SIZE) : UW'(sh);
        return hi + UW'(idx);
    endfunction

    assign op       = op_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    efe_ram #(.WIDTH(DATA_BITS), .DEPTH(BLOCK_SIZE)) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    efe_wdiv #(.BLOCK_SIZE(BLOCK_SIZE)) u_wdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (scan_sum),
        .stat     (div_stat)
    );

    // Running sum of the walk; entries past the count read as zero
    assign scan_sum   = acc_reg + ((CW'(scan_reg) < count_reg) ? ram_rdata : '0);
    assign hidx_clamp = (hidx_reg >= HW'(BLOCK_SIZE)) ? LAST_IDX : IW'(hidx_reg);
    assign hpos       = hi_pos(ram_rdata, lw_reg, (state_reg == ST_HINT_CALC) ?
                               hidx_clamp : eidx_reg);
    assign gap        = hpos - upos_reg;
    assign room       = FULL - fill_reg;

    // Next chunk of the stream for the current phase
    always_comb begin
        ck_v     = '0;
        ck_n     = '0;
        ck_phase = phase_reg;
        ck_idx   = eidx_reg;
        ck_upos  = upos_reg;
        unique case (phase_reg)
            PH_WIDTH: begin
                ck_v     = DATA_BITS'(lw_reg);
                ck_n     = FW'(WIDTH_BITS);
                ck_phase = PH_HINTS;
            end
            PH_HINTS: begin
                ck_v     = hint_reg;
                ck_n     = FULL;
                ck_idx   = '0;
                ck_upos  = '0;
                ck_phase = (lw_reg != '0) ? PH_LOW : PH_HIGH;
            end
            PH_LOW: begin
                ck_v = ram_rdata & ~({DATA_BITS{1'b1}} << lw_reg);
                ck_n = lw_reg;
                if (eidx_reg == LAST_IDX) begin
                    ck_idx   = '0;
                    ck_phase = PH_HIGH;
                end else begin
                    ck_idx = eidx_reg + IW'(1);
                end
            end
            PH_HIGH: begin
                if (hpos > upos_reg && 16'(gap) >= 16'(DATA_BITS)) begin
                    // long run of zeros: emit a full word, stay on this sum
                    ck_n    = FULL;
                    ck_upos = upos_reg + UW'(DATA_BITS);
                end else begin
                    if (hpos > upos_reg) begin
                        ck_v    = DATA_BITS'(1) << gap;
                        ck_n    = FW'(gap) + FW'(1);
                        ck_upos = hpos + UW'(1);
                    end else begin
                        ck_v    = DATA_BITS'(1);
                        ck_n    = FW'(1);
                        ck_upos = upos_reg + UW'(1);
                    end
                    if (eidx_reg == LAST_IDX) begin
                        ck_phase = PH_DONE;
                    end else begin
                        ck_idx = eidx_reg + IW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && op == OP_CLOSE && phase_reg == PH_IDLE && count_reg != '0) begin
                    state_next = ST_SCAN;
                end else if (accept && op == OP_FETCH && phase_reg != PH_IDLE) begin
                    state_next = ST_FETCH;
                end
            end
            ST_SCAN: begin
                if (scan_reg == LAST_IDX) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_HINT_RD;
                end
            end
            ST_HINT_RD: state_next = ST_HINT_CALC;
            ST_HINT_CALC: begin
                state_next = (hp_reg == PW'(SUB_BLOCKS - 2)) ? ST_IDLE : ST_HINT_RD;
            end
            ST_FETCH: begin
                if (fill_reg == FULL || phase_reg == PH_DONE) begin
                    state_next = (fill_reg == '0) ? ST_IDLE : ST_PUSH;
                end else if (phase_reg == PH_LOW || phase_reg == PH_HIGH) begin
                    state_next = ST_FETCH_MEM;
                end
            end
            ST_FETCH_MEM: state_next = ST_FETCH;
            ST_PUSH: begin
                if (!mv_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        acc_next   = acc_reg;
        lw_next    = lw_reg;
        hint_next  = hint_reg;
        hp_next    = hp_reg;
        hidx_next  = hidx_reg;
        eidx_next  = eidx_reg;
        upos_next  = upos_reg;
        pbuf_next  = pbuf_reg;
        pfill_next = pfill_reg;
        word_next  = word_reg;
        fill_next  = fill_reg;
        last_next  = last_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        ram_we     = 1'b0;
        ram_waddr  = IW'(count_reg);
        ram_wdata  = s_tdata;
        ram_raddr  = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && phase_reg == PH_IDLE && op == OP_APPEND
                        && count_reg < CW'(BLOCK_SIZE)) begin
                    ram_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                if (accept && op == OP_CLOSE && phase_reg == PH_IDLE && count_reg != '0) begin
                    scan_next = '0;
                    acc_next  = '0;
                    hint_next = '0;
                end
                if (accept && op == OP_FETCH) begin
                    word_next  = pbuf_reg;
                    fill_next  = pfill_reg;
                    pbuf_next  = '0;
                    pfill_next = '0;
                end
            end
            ST_SCAN: begin
                // write back the running sum, read the next entry
                ram_we    = 1'b1;
                ram_waddr = scan_reg;
                ram_wdata = scan_sum;
                ram_raddr = scan_reg + IW'(1);
                acc_next  = scan_sum;
                scan_next = scan_reg + IW'(1);
                div_start = (scan_reg == LAST_IDX);
            end
            ST_DIV: begin
                lw_next   = div_stat.width;
                hp_next   = '0;
                hidx_next = HW'(STEP - 1);
            end
            ST_HINT_RD: ram_raddr = hidx_clamp;
            ST_HINT_CALC: begin
                ram_raddr = hidx_clamp;
                hint_next[hp_reg * HINT_BITS +: HINT_BITS] = HINT_BITS'(hpos);
                hp_next   = hp_reg + PW'(1);
                hidx_next = hidx_reg + HW'(STEP);
                if (hp_reg == PW'(SUB_BLOCKS - 2)) begin
                    phase_next = PH_WIDTH;
                    eidx_next  = '0;
                    upos_next  = '0;
                    pbuf_next  = '0;
                    pfill_next = '0;
                end
            end
            ST_FETCH, ST_FETCH_MEM: begin
                ram_raddr = eidx_reg;
                if (state_reg == ST_FETCH && (fill_reg == FULL || phase_reg == PH_DONE)) begin
                    // close out the word, mark the end of the stream
                    last_next = (phase_reg == PH_DONE) && (pfill_reg == '0);
                    if (phase_reg == PH_DONE && pfill_reg == '0) begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end else if (state_reg == ST_FETCH_MEM || phase_reg == PH_WIDTH
                             || phase_reg == PH_HINTS) begin
                    // pack the chunk, spill what does not fit
                    phase_next = ck_phase;
                    eidx_next  = ck_idx;
                    upos_next  = ck_upos;
                    word_next  = word_reg | (ck_v << fill_reg);
                    if (ck_n <= room) begin
                        fill_next = fill_reg + ck_n;
                    end else begin
                        pbuf_next  = ck_v >> room;
                        pfill_next = ck_n - room;
                        fill_next  = FULL;
                    end
                end
            end
            ST_PUSH: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    md_next = {1'b0, fill_reg, word_reg};
                    ml_next = last_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            lw_reg    <= '0;
            hint_reg  <= '0;
            hp_reg    <= '0;
            eidx_reg  <= '0;
            upos_reg  <= '0;
            pfill_reg <= '0;
            fill_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            lw_reg    <= lw_next;
            hint_reg  <= hint_next;
            hp_reg    <= hp_next;
            eidx_reg  <= eidx_next;
            upos_reg  <= upos_next;
            pfill_reg <= pfill_next;
            fill_reg  <= fill_next;
            mv_reg    <= mv_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        scan_reg <= scan_next;
        acc_reg  <= acc_next;
        hidx_reg <= hidx_next;
        pbuf_reg <= pbuf_next;
        word_reg <= word_next;
        last_reg <= last_next;
        md_reg   <= md_next;
        ml_reg   <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

endmodule

// ===== rtl/core/efe_checker.sv =====
`include "elias_fano_block_encoder_macros.svh"

module efe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tlast
);

    // Hold a stalled beat
    `EFE_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled beat changed")

    // Bit count stays within one word
    `EFE_ASSERT_NOW(a_count, m_tvalid, m_tdata[70:64] != 7'd0 && m_tdata[70:64] <= 7'd64, "bad bit count")

    // Only the last beat of a stream may be short
    `EFE_ASSERT_NOW(a_full, m_tvalid && !m_tlast, m_tdata[70:64] == 7'd64, "short beat before end of stream")

    // Pad bit stays zero
    `EFE_ASSERT_NOW(a_pad, m_tvalid, m_tdata[71] == 1'b0, "pad bit set")

endmodule

bind elias_fano_block_encoder efe_checker u_efe_checker (.*);
